// ===== hw/rtl/nmz_pkg.sv =====
// Shared types and constants for the sensor min/max normalizer.
`timescale 1ns / 1ps

package nmz_pkg;

   localparam int LEVEL_W = 10;            // resolution, threshold and level width
   localparam int CH_W    = 3;             // channel field width
   localparam int IND_W   = 8;             // indicator pattern width
   localparam int ADDR_W  = 3;             // register byte address width
   localparam int DATA_W  = 32;            // register data width
   localparam int CNT_W   = $clog2(LEVEL_W);

   localparam logic [LEVEL_W-1:0] RESOLUTION_RESET = 10'd100;
   localparam logic [LEVEL_W-1:0] THRESHOLD_RESET  = 10'd60;

   typedef enum logic [0:0] {
      REG_RESOLUTION = 1'b0,
      REG_THRESHOLD  = 1'b1
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAX,
      ST_MIN,
      ST_SPAN,
      ST_DIFF,
      ST_MUL,
      ST_DIV,
      ST_THR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] resolution;
      logic [LEVEL_W-1:0] threshold;
   } cfg_type;

endpackage

// ===== hw/rtl/nmz_csr.sv =====
// APB-style register file holding resolution and threshold.
`timescale 1ns / 1ps

module nmz_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [nmz_pkg::ADDR_W-1:0]  paddr,
   input  logic [nmz_pkg::DATA_W-1:0]  pwdata,
   output logic [nmz_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output nmz_pkg::cfg_type            cfg
);

   logic [nmz_pkg::LEVEL_W-1:0] res_ff, res_in;
   logic [nmz_pkg::LEVEL_W-1:0] thr_ff, thr_in;
   nmz_pkg::reg_idx_type        idx;
   logic                        wr_en;

   assign idx    = nmz_pkg::reg_idx_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      res_in = res_ff;
      thr_in = thr_ff;
      prdata = '0;
      unique case (idx)
         nmz_pkg::REG_RESOLUTION: begin
            prdata = nmz_pkg::DATA_W'(res_ff);
            if (wr_en) res_in = pwdata[nmz_pkg::LEVEL_W-1:0];
         end
         nmz_pkg::REG_THRESHOLD: begin
            prdata = nmz_pkg::DATA_W'(thr_ff);
            if (wr_en) thr_in = pwdata[nmz_pkg::LEVEL_W-1:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= nmz_pkg::RESOLUTION_RESET;
         thr_ff <= nmz_pkg::THRESHOLD_RESET;
      end else begin
         res_ff <= res_in;
         thr_ff <= thr_in;
      end
   end

   assign cfg.resolution = res_ff;
   assign cfg.threshold  = thr_ff;

endmodule

// ===== hw/rtl/nmz_alu.sv =====
// Shared subtract/compare unit: difference and borrow of two unsigned operands.
`timescale 1ns / 1ps

module nmz_alu #(
   parameter int W = 11
) (
   input  logic [W-1:0] op_a,
   input  logic [W-1:0] op_b,
   output logic [W-1:0] diff,
   output logic         borrow
);

   // borrow set means op_a < op_b
   assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

endmodule

// ===== hw/rtl/nmz_core.sv =====
// Sequencer, min/max store and datapath around the shared subtractor.
`timescale 1ns / 1ps

module nmz_core #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nmz_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nmz_pkg::CH_W-1:0]      req_channel,
   input  logic [SAMPLE_BITS-1:0]        req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nmz_pkg::CH_W-1:0]      rsp_result_channel,
   output logic [nmz_pkg::LEVEL_W-1:0]   rsp_level,
   output logic                          rsp_line_seen,
   output logic [nmz_pkg::IND_W-1:0]     rsp_indicator_pattern,
   output logic                          rsp_span_zero
);

   localparam int LW       = nmz_pkg::LEVEL_W;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W    = ((CH_IDX_W > nmz_pkg::CH_W) ? CH_IDX_W : nmz_pkg::CH_W) + 1;
   localparam int UNIT_W   = (SAMPLE_BITS + 1 > LW) ? SAMPLE_BITS + 1 : LW;
   localparam int PROD_W   = LW + SAMPLE_BITS;

   nmz_pkg::state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] max_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] min_ff [CHANNELS];
   logic                   upd_en;

   logic [nmz_pkg::CH_W-1:0]  ch_ff, ch_in;
   logic [SAMPLE_BITS-1:0]    smp_ff, smp_in;
   logic [SAMPLE_BITS-1:0]    hi_ff, hi_in;
   logic [SAMPLE_BITS-1:0]    lo_ff, lo_in;
   logic [SAMPLE_BITS-1:0]    span_ff, span_in;
   logic [SAMPLE_BITS-1:0]    diff_ff, diff_in;
   logic [SAMPLE_BITS-1:0]    rem_ff, rem_in;
   logic [LW-1:0]             quo_ff, quo_in;   // low numerator bits, then quotient
   logic [nmz_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      seen_ff, seen_in;
   logic                      zero_ff, zero_in;
   logic [nmz_pkg::IND_W-1:0] ind_ff, ind_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [nmz_pkg::CH_W-1:0]  rsp_ch_ff, rsp_ch_in;
   logic [LW-1:0]             rsp_level_ff, rsp_level_in;
   logic                      rsp_seen_ff, rsp_seen_in;
   logic [nmz_pkg::IND_W-1:0] rsp_ind_ff, rsp_ind_in;
   logic                      rsp_zero_ff, rsp_zero_in;

   logic [CMP_W-1:0]       ch_ext;
   logic                   in_range;
   logic [CH_IDX_W-1:0]    idx;
   logic [SAMPLE_BITS-1:0] max_rd;
   logic [SAMPLE_BITS-1:0] min_rd;
   logic [SAMPLE_BITS:0]   trial;
   logic [PROD_W-1:0]      prod;
   logic                   out_free;

   logic [UNIT_W-1:0] alu_a, alu_b, alu_diff;
   logic              alu_borrow;

   nmz_alu #(.W(UNIT_W)) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   assign ch_ext   = CMP_W'(ch_ff);
   assign in_range = ch_ext < CMP_W'(CHANNELS);
   assign idx      = in_range ? ch_ext[CH_IDX_W-1:0] : '0;
   assign max_rd   = max_ff[idx];
   assign min_rd   = min_ff[idx];
   assign trial    = {rem_ff, quo_ff[LW-1]};
   assign prod     = PROD_W'(cfg.resolution) * PROD_W'(diff_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == nmz_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      smp_in       = smp_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      diff_in      = diff_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      seen_in      = seen_ff;
      zero_in      = zero_ff;
      ind_in       = ind_ff;
      upd_en       = 1'b0;
      alu_a        = '0;
      alu_b        = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_level_in = rsp_level_ff;
      rsp_seen_in  = rsp_seen_ff;
      rsp_ind_in   = rsp_ind_ff;
      rsp_zero_in  = rsp_zero_ff;

      unique case (state_ff)
         nmz_pkg::ST_IDLE: begin
            if (req_valid) begin
               ch_in    = req_channel;
               smp_in   = req_sample;
               quo_in   = '0;
               seen_in  = 1'b0;
               zero_in  = 1'b0;
               state_in = nmz_pkg::ST_MAX;
            end
         end
         nmz_pkg::ST_MAX: begin
            alu_a = UNIT_W'(max_rd);
            alu_b = UNIT_W'(smp_ff);
            hi_in = alu_borrow ? smp_ff : max_rd;
            state_in = in_range ? nmz_pkg::ST_MIN : nmz_pkg::ST_DONE;
         end
         nmz_pkg::ST_MIN: begin
            alu_a    = UNIT_W'(smp_ff);
            alu_b    = UNIT_W'(min_rd);
            lo_in    = alu_borrow ? smp_ff : min_rd;
            upd_en   = 1'b1;
            state_in = nmz_pkg::ST_SPAN;
         end
         nmz_pkg::ST_SPAN: begin
            alu_a   = UNIT_W'(hi_ff);
            alu_b   = UNIT_W'(lo_ff);
            span_in = alu_diff[SAMPLE_BITS-1:0];
            zero_in = (span_in == '0);
            state_in = zero_in ? nmz_pkg::ST_THR : nmz_pkg::ST_DIFF;
         end
         nmz_pkg::ST_DIFF: begin
            alu_a    = UNIT_W'(hi_ff);
            alu_b    = UNIT_W'(smp_ff);
            diff_in  = alu_diff[SAMPLE_BITS-1:0];
            state_in = nmz_pkg::ST_MUL;
         end
         nmz_pkg::ST_MUL: begin
            // upper part is below span since the quotient fits in LW bits
            rem_in   = prod[PROD_W-1:LW];
            quo_in   = prod[LW-1:0];
            cnt_in   = '0;
            state_in = nmz_pkg::ST_DIV;
         end
         nmz_pkg::ST_DIV: begin
            alu_a  = UNIT_W'(trial);
            alu_b  = UNIT_W'(span_ff);
            rem_in = alu_borrow ? trial[SAMPLE_BITS-1:0] : alu_diff[SAMPLE_BITS-1:0];
            quo_in = {quo_ff[LW-2:0], !alu_borrow};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == nmz_pkg::CNT_W'(LW - 1)) state_in = nmz_pkg::ST_THR;
         end
         nmz_pkg::ST_THR: begin
            alu_a   = UNIT_W'(quo_ff);
            alu_b   = UNIT_W'(cfg.threshold);
            seen_in = !alu_borrow;
            ind_in[ch_ff] = alu_borrow;   // active low
            state_in = nmz_pkg::ST_DONE;
         end
         nmz_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_level_in = quo_ff;
               rsp_seen_in  = seen_ff;
               rsp_ind_in   = ind_ff;
               rsp_zero_in  = zero_ff;
               state_in     = nmz_pkg::ST_IDLE;
            end
         end
         default: state_in = nmz_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nmz_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ind_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ind_ff       <= ind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            max_ff[i] <= '0;
            min_ff[i] <= '1;
         end
      end else if (upd_en) begin
         max_ff[idx] <= hi_ff;
         min_ff[idx] <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      smp_ff       <= smp_in;
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
      span_ff      <= span_in;
      diff_ff      <= diff_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      seen_ff      <= seen_in;
      zero_ff      <= zero_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_level_ff <= rsp_level_in;
      rsp_seen_ff  <= rsp_seen_in;
      rsp_ind_ff   <= rsp_ind_in;
      rsp_zero_ff  <= rsp_zero_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_channel    = rsp_ch_ff;
   assign rsp_level             = rsp_level_ff;
   assign rsp_line_seen         = rsp_seen_ff;
   assign rsp_indicator_pattern = rsp_ind_ff;
   assign rsp_span_zero         = rsp_zero_ff;

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nmz_pkg::ST_DIV) |-> (rem_ff < span_ff))
      else $error("division remainder not below span");

   a_zero_span_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zero_ff) |-> (rsp_level_ff == '0))
      else $error("zero span with nonzero level");

   a_level_in_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= cfg.resolution))
      else $error("level above resolution");

   a_seen_clears_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_seen_ff) |-> !rsp_ind_ff[rsp_ch_ff])
      else $error("line seen but indicator bit set");

endmodule

// ===== hw/rtl/sensor_minmax_normalizer.sv =====
// Top level of the per-channel min/max reflectance normalizer.
`timescale 1ns / 1ps
//
//  channel | ports                                           | role
//  --------+-------------------------------------------------+-------------------------------
//  req     | req_valid/req_ready, req_channel, req_sample    | one raw sample per transfer
//  rsp     | rsp_valid/rsp_ready, rsp_result_channel,        | one result per transfer
//          | rsp_level, rsp_line_seen, rsp_indicator_pattern,|
//          | rsp_span_zero                                   |
//  csr     | psel, penable, pwrite, paddr, pwdata, prdata,   | 0x0 resolution, 0x4 threshold
//          | pready                                          |
//
//  Sequence: a zero-span sample skips distance, product and division; a
//  channel at or above CHANNELS goes from the max compare to the result. The
//  ten restoring-division steps use the one shared subtractor, which also does
//  the max/min compares, span and distance subtracts and the threshold
//  compare; the product resolution*(max-sample) is registered first.
//  Reset: synchronous, active high; min/max tables, indicator and registers
//  return to their reset values at once, no clearing pass.
//  Stalls: the result sits in an output register; a new sample is taken while
//  it waits, and the sequencer only holds in its final step if the previous
//  result has still not been taken.
//
module sensor_minmax_normalizer #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nmz_pkg::CH_W-1:0]      req_channel,
   input  logic [SAMPLE_BITS-1:0]        req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nmz_pkg::CH_W-1:0]      rsp_result_channel,
   output logic [nmz_pkg::LEVEL_W-1:0]   rsp_level,
   output logic                          rsp_line_seen,
   output logic [nmz_pkg::IND_W-1:0]     rsp_indicator_pattern,
   output logic                          rsp_span_zero,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [nmz_pkg::ADDR_W-1:0]    paddr,
   input  logic [nmz_pkg::DATA_W-1:0]    pwdata,
   output logic [nmz_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   nmz_pkg::cfg_type cfg;

   // register file; the user must ensure config only changes while the core is idle; the block has no check for it
   nmz_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer, running min/max per channel and the shared-unit datapath
   nmz_core #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_channel           (req_channel),
      .req_sample            (req_sample),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_channel    (rsp_result_channel),
      .rsp_level             (rsp_level),
      .rsp_line_seen         (rsp_line_seen),
      .rsp_indicator_pattern (rsp_indicator_pattern),
      .rsp_span_zero         (rsp_span_zero)
   );

endmodule
